// File: rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, round constants and initial hash values.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_data;
    logic       load;
    logic       round;
    logic       add;
    logic       init;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] round_idx;
  } dp_stat_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

// File: rtl/sha256_if.sv
// ----------------------------------------------------------------------------
// SHA-256 stream channels
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       has_byte;
  logic       is_last;
  modport source (output valid, msg_byte, has_byte, is_last, input ready);
  modport sink   (input valid, msg_byte, has_byte, is_last, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: rtl/sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with one compression round per cycle.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while a block fills; each full block then
// passes through the round unit in order: load, 64 rounds, hash add.
// Last item: padding writes up to 64 bytes per extra block, one per cycle,
// then eight digest words are offered, one per cycle while ready is high.
// Reset: asynchronous, active low; hash words return to initial values.
module sha256_stream_hasher_core import sha256_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sha256_in_if.sink   in_ch,
  sha256_out_if.source out_ch
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [2:0] idx;

  sha256_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .in_byte_i  (in_ch.msg_byte),
    .in_has_i   (in_ch.has_byte),
    .in_last_i  (in_ch.is_last),
    .out_ready_i(out_ch.ready),
    .out_valid_o(out_ch.valid),
    .out_idx_o  (idx),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sha256_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .rd_idx_i (idx),
    .rd_word_o(out_ch.digest_word),
    .stat_o   (stat)
  );

  assign out_ch.word_index = idx;
  assign out_ch.last_word  = (idx == 3'd7);

endmodule

// File: rtl/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_has_i,
  input  logic        in_last_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [2:0]  out_idx_o,
  input  dp_stat_t    stat_i,
  output dp_cmd_t     cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        fin_q, fin_d;      // padding pending after block
  logic        pad_q, pad_d;      // 0x80 already placed
  logic        tail_q, tail_d;    // rest of block is zero, length goes in next block
  logic [63:0] bits_q, bits_d;
  logic [60:0] total_q, total_d;
  logic [2:0]  idx_q, idx_d;
  logic [7:0]  pad_byte;
  logic        acc;

  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    if (!pad_q) begin
      pad_byte = PadByte;
    end else if (stat_i.fill < LenPos || tail_q) begin
      pad_byte = '0;
    end else begin
      pad_byte = bits_q[63 - 8*stat_i.fill[2:0] -: 8];
    end
  end

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    pad_d   = pad_q;
    tail_d  = tail_q;
    bits_d  = bits_q;
    total_d = total_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_FILL: begin
        if (acc) begin
          if (in_has_i) begin
            total_d = total_q + 61'd1;
          end
          if (in_last_i) begin
            fin_d  = 1'b1;
            pad_d  = 1'b0;
            bits_d = {total_d, 3'b000};
          end
          if (in_has_i && stat_i.fill == 6'd63) begin
            state_d = ST_LOAD;
          end else if (in_last_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        pad_d = 1'b1;
        if (!pad_q) begin
          tail_d = (stat_i.fill >= LenPos);
        end
        if (stat_i.fill == 6'd63) begin
          state_d = ST_LOAD;
          tail_d  = 1'b0;
          if (pad_q && !tail_q) begin
            fin_d = 1'b0;
          end
        end
      end
      ST_LOAD:  state_d = ST_ROUND;
      ST_ROUND: if (stat_i.round_idx == 6'd63) state_d = ST_ADD;
      ST_ADD: begin
        if (fin_q) begin
          state_d = ST_PAD;
        end else if (pad_q) begin
          state_d = ST_EMIT;
          idx_d   = '0;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            state_d = ST_FILL;
            pad_d   = 1'b0;
            total_d = '0;
          end
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_FILL: begin
        in_ready_o    = 1'b1;
        cmd_o.wr_en   = acc && in_has_i;
        cmd_o.wr_data = in_byte_i;
      end
      ST_PAD: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_data = pad_byte;
      end
      ST_LOAD:  cmd_o.load  = 1'b1;
      ST_ROUND: cmd_o.round = 1'b1;
      ST_ADD:   cmd_o.add   = 1'b1;
      ST_EMIT: begin
        out_valid_o = 1'b1;
        cmd_o.init  = out_ready_i && idx_q == 3'd7;
      end
      default: ;
    endcase
  end

  assign out_idx_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      fin_q   <= 1'b0;
      pad_q   <= 1'b0;
      tail_q  <= 1'b0;
      total_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      pad_q   <= pad_d;
      tail_q  <= tail_d;
      total_q <= total_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
  end

endmodule

// File: rtl/sha256_dp.sv
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Message schedule window, round registers and hash words.
// ----------------------------------------------------------------------------
module sha256_dp import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [2:0]  rd_idx_i,
  output logic [31:0] rd_word_o,
  output dp_stat_t    stat_o
);

  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [5:0]  fill_q, rnd_q;
  logic [31:0] s0, s1, wn, wt, t1, t2, ch, maj, e1, a0;
  logic [3:0]  wr_word;
  logic [4:0]  wr_lsb;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  // bytes land big-endian straight in the schedule window
  assign wr_word = fill_q[5:2];
  assign wr_lsb  = {~fill_q[1:0], 3'b000};

  // window shifts each round; w_q[0] is the current word
  assign s0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wn = w_q[0] + s0 + w_q[9] + s1;
  assign wt = w_q[0];
  assign e1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
  assign a0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
  assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1 = v_q[7] + e1 + ch + RoundK[rnd_q] + wt;
  assign t2 = a0 + maj;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      w_q[wr_word][wr_lsb +: 8] <= cmd_i.wr_data;
    end else if (cmd_i.round) begin
      for (int j = 0; j < 15; j++) begin
        w_q[j] <= w_q[j+1];
      end
      w_q[15] <= wn;
    end
    if (cmd_i.load) begin
      for (int j = 0; j < 8; j++) begin
        v_q[j] <= h_q[j];
      end
    end else if (cmd_i.round) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rnd_q  <= '0;
      for (int j = 0; j < 8; j++) begin
        h_q[j] <= InitH[j];
      end
    end else begin
      if (cmd_i.wr_en) begin
        fill_q <= fill_q + 6'd1;
      end
      if (cmd_i.load) begin
        rnd_q <= '0;
      end else if (cmd_i.round) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (cmd_i.add) begin
        for (int j = 0; j < 8; j++) begin
          h_q[j] <= h_q[j] + v_q[j];
        end
      end else if (cmd_i.init) begin
        for (int j = 0; j < 8; j++) begin
          h_q[j] <= InitH[j];
        end
      end
    end
  end

  assign rd_word_o        = h_q[rd_idx_i];
  assign stat_o.fill      = fill_q;
  assign stat_o.round_idx = rnd_q;

endmodule
